FILE: rtl/hweo_pkg.sv
// Shared types and constants for the hysteresis wheel encoder odometer.
// Holds field widths, register codes, reset values and the structs passed
// between the front end, the command queue, the back end and the dividers.
package hweo_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int SEG_W     = 15;
  localparam int CIRC_W    = 15;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;

  // Default queue depths
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // Divider sizing: |delta| * 1000 * circ fits in 57 bits,
  // interval * segments fits in 47 bits, and an unsaturated quotient in 31.
  localparam int NUM_W = 57;
  localparam int DEN_W = 47;
  localparam int QUO_W = 31;
  localparam int K_W   = 25;

  localparam logic [31:0] WINDOW_MS = 32'd50;
  localparam logic [9:0]  MS_PER_S  = 10'd1000;

  localparam logic [SAMPLE_W-1:0] UPPER_RST = 12'd2500;
  localparam logic [SAMPLE_W-1:0] LOWER_RST = 12'd1500;
  localparam logic [SEG_W-1:0]    SEG_RST   = 15'd8;
  localparam logic [CIRC_W-1:0]   CIRC_RST  = 15'd200;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER    = 3'd0,
    REG_LOWER    = 3'd1,
    REG_SEGMENTS = 3'd2,
    REG_CIRCUMF  = 3'd3,
    REG_BACKWARD = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] upper;
    logic [SAMPLE_W-1:0] lower;
    logic [SEG_W-1:0]    seg;
    logic [CIRC_W-1:0]   circ;
    logic                backward;
  } cfg_t;

  // Work handed from the front end to the back end
  typedef struct packed {
    logic [31:0] tick;
    logic [31:0] delta;
    logic [31:0] interval;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] tick_count;
    logic signed [31:0] distance;
    logic signed [31:0] velocity;
  } res_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

endpackage

FILE: rtl/hysteresis_wheel_encoder_odometer.sv
// Top level of the hysteresis wheel encoder odometer: config registers and queues.
// Depends on hweo_pkg, hweo_fifo, hweo_front, hweo_back (and hweo_div below it).
//
//   channel   handshake            payload
//   input     in_push / in_full    in_action, in_sample, in_now_ms
//   result    out_pop / out_empty  out_tick_count, out_distance, out_velocity
//   config    cfg_we               cfg_index, cfg_wdata
//
// A result reaches the result ports after its transaction passes the command queue,
// the back end's operand and multiply stages, the two 31-step restoring dividers
// running side by side and the push state. The back end takes a new command only
// once the last result is pushed, and the front end accepts each cycle
// until the command queue is full. Reset is synchronous, active low, no clearing pass.
// A full result queue stalls the back end, which in turn fills the command queue.
module hysteresis_wheel_encoder_odometer #(
  parameter int CMD_DEPTH = hweo_pkg::CMD_DEPTH,
  parameter int RES_DEPTH = hweo_pkg::RES_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_action,
  input  logic [hweo_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [31:0]                    in_now_ms,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic signed [31:0]             out_tick_count,
  output logic signed [31:0]             out_distance,
  output logic signed [31:0]             out_velocity,
  input  logic                           cfg_we,
  input  logic [hweo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hweo_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int SAMPLE_W = hweo_pkg::SAMPLE_W;

  hweo_pkg::cfg_t cfg_r;
  hweo_pkg::cmd_t cmd_in;
  hweo_pkg::cmd_t cmd_out;
  hweo_pkg::res_t res_in;
  hweo_pkg::res_t res_out;
  logic           cmd_push;
  logic           cmd_full;
  logic           cmd_pop;
  logic           cmd_empty;
  logic           res_push;
  logic           res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upper    <= hweo_pkg::UPPER_RST;
      cfg_r.lower    <= hweo_pkg::LOWER_RST;
      cfg_r.seg      <= hweo_pkg::SEG_RST;
      cfg_r.circ     <= hweo_pkg::CIRC_RST;
      cfg_r.backward <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        hweo_pkg::REG_UPPER:    cfg_r.upper    <= cfg_wdata[SAMPLE_W-1:0];
        hweo_pkg::REG_LOWER:    cfg_r.lower    <= cfg_wdata[SAMPLE_W-1:0];
        hweo_pkg::REG_SEGMENTS: cfg_r.seg      <= cfg_wdata[hweo_pkg::SEG_W-1:0];
        hweo_pkg::REG_CIRCUMF:  cfg_r.circ     <= cfg_wdata[hweo_pkg::CIRC_W-1:0];
        hweo_pkg::REG_BACKWARD: cfg_r.backward <= cfg_wdata[0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  hweo_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_push   (in_push),
    .in_action (in_action),
    .in_sample (in_sample),
    .in_now_ms (in_now_ms),
    .in_full   (in_full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in),
    .cmd_full  (cmd_full)
  );

  hweo_fifo #(
    .DEPTH (CMD_DEPTH),
    .WIDTH ($bits(hweo_pkg::cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  hweo_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  hweo_fifo #(
    .DEPTH (RES_DEPTH),
    .WIDTH ($bits(hweo_pkg::res_t))
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_tick_count = res_out.tick_count;
  assign out_distance   = res_out.distance;
  assign out_velocity   = res_out.velocity;

endmodule

FILE: rtl/hweo_fifo.sv
// Small first-word-fall-through queue of packed words.
// Used for the command queue and the result queue; no package dependency.
module hweo_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/hweo_div.sv
// Restoring divider, one quotient bit per cycle, with an up-front saturation test.
// Depends on hweo_pkg for NUM_W, DEN_W, QUO_W and div_stat_t.
module hweo_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [hweo_pkg::NUM_W-1:0] num,
  input  logic [hweo_pkg::DEN_W-1:0] den,
  output hweo_pkg::div_stat_t     stat,
  output logic [hweo_pkg::QUO_W-1:0] quo
);

  localparam int NUM_W = hweo_pkg::NUM_W;
  localparam int DEN_W = hweo_pkg::DEN_W;
  localparam int QUO_W = hweo_pkg::QUO_W;
  localparam int HI_W  = NUM_W - QUO_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [QUO_W-1:0] bits_r;
  logic [QUO_W-1:0] q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             sat_r;

  logic [DEN_W-1:0] hi_ext;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Quotient reaches 2^31 exactly when the upper numerator bits reach the divisor
  assign hi_ext = {{(DEN_W - HI_W){1'b0}}, num[NUM_W-1:QUO_W]};
  assign trial  = {rem_r, bits_r[QUO_W-1]};
  assign diff   = trial - {1'b0, den_r};
  assign ge     = (trial >= {1'b0, den_r});

  assign stat.done = done_r;
  assign stat.sat  = sat_r;
  assign quo       = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= hi_ext;
      den_r  <= den;
      bits_r <= num[QUO_W-1:0];
      q_r    <= '0;
      sat_r  <= (hi_ext >= den);
    end else if (busy_r) begin
      rem_r  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      bits_r <= {bits_r[QUO_W-2:0], 1'b0};
      q_r    <= {q_r[QUO_W-2:0], ge};
    end
  end

endmodule

FILE: rtl/hweo_front.sv
// Front end: accepts input transactions, runs the hysteresis detector and window.
// Depends on hweo_pkg; pushes one command per transaction into the command queue.
module hweo_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hweo_pkg::cfg_t                cfg,
  input  logic                          in_push,
  input  logic                          in_action,
  input  logic [hweo_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [31:0]                   in_now_ms,
  output logic                          in_full,
  output logic                          cmd_push,
  output hweo_pkg::cmd_t                cmd_data,
  input  logic                          cmd_full
);

  logic        wait_low_r;
  logic [31:0] ticks_r;
  logic [31:0] win_ticks_r;
  logic [31:0] win_time_r;
  logic [31:0] delta_r;
  logic [31:0] interval_r;

  logic        accept;
  logic        hit;
  logic [31:0] step_val;
  logic [31:0] ticks_upd;
  logic [31:0] elapsed;
  logic        win_close;
  logic [31:0] delta_upd;
  logic [31:0] interval_upd;

  assign in_full  = cmd_full;
  assign accept   = in_push && !cmd_full;
  assign cmd_push = accept;

  always_comb begin
    step_val     = cfg.backward ? 32'hFFFF_FFFF : 32'd1;
    hit          = wait_low_r ? (in_sample <= cfg.lower) : (in_sample >= cfg.upper);
    ticks_upd    = hit ? ticks_r + step_val : ticks_r;
    elapsed      = in_now_ms - win_time_r;
    win_close    = (elapsed > hweo_pkg::WINDOW_MS);
    delta_upd    = win_close ? ticks_upd - win_ticks_r : delta_r;
    interval_upd = win_close ? elapsed : interval_r;

    if (in_action == hweo_pkg::ACT_CLEAR) begin
      cmd_data.tick     = '0;
      cmd_data.delta    = '0;
      cmd_data.interval = 32'd1;
    end else begin
      cmd_data.tick     = ticks_upd;
      cmd_data.delta    = delta_upd;
      cmd_data.interval = interval_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_low_r  <= 1'b0;
      ticks_r     <= '0;
      win_ticks_r <= '0;
      win_time_r  <= '0;
      delta_r     <= '0;
      interval_r  <= 32'd1;
    end else if (accept) begin
      if (in_action == hweo_pkg::ACT_CLEAR) begin
        // keep the detector phase, restart everything else
        ticks_r     <= '0;
        win_ticks_r <= '0;
        win_time_r  <= in_now_ms;
        delta_r     <= '0;
        interval_r  <= 32'd1;
      end else begin
        if (hit) begin
          wait_low_r <= !wait_low_r;
        end
        ticks_r <= ticks_upd;
        if (win_close) begin
          win_ticks_r <= ticks_upd;
          win_time_r  <= in_now_ms;
          delta_r     <= delta_upd;
          interval_r  <= interval_upd;
        end
      end
    end
  end

endmodule

FILE: rtl/hweo_back.sv
// Back end: turns a command into distance and velocity with two parallel dividers.
// Depends on hweo_pkg and hweo_div; pushes one result per command.
module hweo_back (
  input  logic           clk,
  input  logic           rst_n,
  input  hweo_pkg::cfg_t cfg,
  input  logic           cmd_empty,
  input  hweo_pkg::cmd_t cmd_data,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output hweo_pkg::res_t res_data
);

  localparam int NUM_W = hweo_pkg::NUM_W;
  localparam int DEN_W = hweo_pkg::DEN_W;
  localparam int QUO_W = hweo_pkg::QUO_W;
  localparam int K_W   = hweo_pkg::K_W;
  localparam int SEG_W = hweo_pkg::SEG_W;
  localparam int DPROD_W = 32 + hweo_pkg::CIRC_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MUL2,
    ST_DIV,
    ST_PUSH
  } state_t;

  state_t             state_r;
  logic               start_r;
  logic [31:0]        tick_r;
  logic [31:0]        abs_t_r;
  logic [31:0]        abs_d_r;
  logic               neg_t_r;
  logic               neg_d_r;
  logic [31:0]        interval_r;
  logic [NUM_W-1:0]   num_d_r;
  logic [NUM_W-1:0]   num_v_r;
  logic [DEN_W-1:0]   den_v_r;
  logic [K_W-1:0]     k_r;
  hweo_pkg::res_t     res_r;

  logic [DPROD_W-1:0] prod_d;
  logic [K_W-1:0]     k_val;
  logic [DEN_W-1:0]   prod_den;
  logic [NUM_W-1:0]   prod_v;
  logic [DEN_W-1:0]   den_d;
  hweo_pkg::div_stat_t stat_d;
  hweo_pkg::div_stat_t stat_v;
  logic [QUO_W-1:0]   quo_d;
  logic [QUO_W-1:0]   quo_v;

  function automatic logic [31:0] to_s32(input logic zero, input logic neg,
                                         input logic sat, input logic [QUO_W-1:0] q);
    logic [31:0] mag;
    mag = {1'b0, q};
    if (zero) begin
      to_s32 = '0;
    end else if (sat) begin
      to_s32 = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      to_s32 = neg ? (~mag + 32'd1) : mag;
    end
  endfunction

  assign prod_d   = abs_t_r * cfg.circ;
  assign k_val    = cfg.circ * hweo_pkg::MS_PER_S;
  assign prod_den = interval_r * cfg.seg;
  assign prod_v   = abs_d_r * k_r;
  assign den_d    = {{(DEN_W - SEG_W){1'b0}}, cfg.seg};

  assign cmd_pop  = (state_r == ST_IDLE) && !cmd_empty;
  assign res_push = (state_r == ST_PUSH) && !res_full;
  assign res_data = res_r;

  hweo_div u_div_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .num   (num_d_r),
    .den   (den_d),
    .stat  (stat_d),
    .quo   (quo_d)
  );

  hweo_div u_div_vel (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .num   (num_v_r),
    .den   (den_v_r),
    .stat  (stat_v),
    .quo   (quo_v)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (!cmd_empty) begin
            tick_r     <= cmd_data.tick;
            neg_t_r    <= cmd_data.tick[31];
            neg_d_r    <= cmd_data.delta[31];
            abs_t_r    <= cmd_data.tick[31] ? (~cmd_data.tick + 32'd1) : cmd_data.tick;
            abs_d_r    <= cmd_data.delta[31] ? (~cmd_data.delta + 32'd1) : cmd_data.delta;
            interval_r <= cmd_data.interval;
            state_r    <= ST_MUL;
          end
        end
        ST_MUL: begin
          num_d_r <= {{(NUM_W - DPROD_W){1'b0}}, prod_d};
          k_r     <= k_val;
          den_v_r <= prod_den;
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          num_v_r <= prod_v;
          start_r <= 1'b1;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (stat_d.done && stat_v.done) begin
            res_r.tick_count <= tick_r;
            res_r.distance   <= to_s32(cfg.seg == '0, neg_t_r, stat_d.sat, quo_d);
            res_r.velocity   <= to_s32(cfg.seg == '0, neg_d_r, stat_v.sat, quo_v);
            state_r          <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!res_full) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/hweo_chk.sv
// Port-level checker for the odometer top level, attached by a bind statement.
// Needs no package; all widths follow the top level's ports.
module hweo_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_full,
  input logic                           out_empty,
  input logic                           out_pop,
  input logic signed [31:0]             out_tick_count,
  input logic signed [31:0]             out_distance,
  input logic signed [31:0]             out_velocity
);

  // Leaving reset, the result queue is empty and the command queue is not full
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // Hold a waiting result until it is taken
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_tick_count)
      && $stable(out_distance) && $stable(out_velocity)))
    else $error("waiting result changed before pop");

  // Distance never carries the opposite sign of the tick count
  a_dist_sign: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_distance[31] && !out_tick_count[31]))
    else $error("negative distance with non-negative ticks");

  a_dist_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_tick_count[31]) |-> (out_distance[31] || out_distance == 32'sd0))
    else $error("positive distance with negative ticks");

  // No ticks means no distance
  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_tick_count == 32'sd0) |-> (out_distance == 32'sd0))
    else $error("nonzero distance with zero ticks");

endmodule

bind hysteresis_wheel_encoder_odometer hweo_chk u_hweo_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_tick_count (out_tick_count),
  .out_distance   (out_distance),
  .out_velocity   (out_velocity)
);
